### design/agc_pkg.sv
// agc_pkg: shared types, constants and codes for the audio gain controller
// no dependencies
`timescale 1ns / 1ps
package agc_pkg;

    localparam int SEARCH_STEPS = 20;

    localparam logic [16:0] TX_MIN = 17'd410;
    localparam logic [16:0] TX_MAX = 17'd12953;
    localparam logic [16:0] RX_MIN = 17'd4096;
    localparam logic [16:0] RX_MAX = 17'd64917;
    localparam logic [16:0] UNITY  = 17'd4096;
    localparam logic [16:0] DOWN_3DB = 17'd46396;
    localparam logic [16:0] UP_3DB   = 17'd92572;
    localparam logic [16:0] UP_1P5DB = 17'd77890;
    localparam logic [31:0] CAL_TIMEOUT    = 32'd20;
    localparam logic [31:0] CAL_SLOW_AFTER = 32'd5;
    localparam logic [2:0]  STEADY_SETTLE  = 3'd5;
    localparam logic [16:0] SMOOTH_TOL     = 17'd40;

    localparam logic [2:0] CFG_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_RMS_MIN = 3'd1;
    localparam logic [2:0] CFG_RMS_MAX = 3'd2;
    localparam logic [2:0] CFG_TARGET  = 3'd3;
    localparam logic [2:0] CFG_ALPHA   = 3'd4;
    localparam logic [2:0] CFG_ATTACK  = 3'd5;
    localparam logic [2:0] CFG_RELEASE = 3'd6;
    localparam logic [2:0] CFG_ECHO    = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POWER,
        ST_EMA,
        ST_DECIDE,
        ST_BRANCH,
        ST_DIV,
        ST_FACTOR,
        ST_SMOOTH,
        ST_SCALE,
        ST_DONE
    } agc_state_t;

    typedef struct packed {
        logic load;
        logic power;
        logic ema;
        logic decide;
        logic div_start;
        logic factor;
        logic smooth;
        logic scale;
    } agc_cmd_t;

    typedef struct packed {
        logic need_ratio;
        logic need_scale;
        logic div_busy;
    } agc_status_t;

endpackage

### design/audio_gain_controller.sv
// audio_gain_controller: top level, sequencer plus datapath
// depends on agc_pkg, agc_ctrl, agc_dp, agc_div
// sequence: load, power, EMA, decide, branch, done; a guard step adds scale,
// and the steady loop adds its 40-step radix-2 divide, factor, smooth and scale
// one item in flight: next input taken the cycle after the result transaction
// reset: synchronous active-low aresetn restores gains, bounds, config and state
`timescale 1ns / 1ps
module audio_gain_controller (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // now_secs[31:0], rms_level[47:32], sync_total[79:48], packet_total[111:80],
    // corrupt_total[143:112], freeze[144], zero fill
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tx_gain[16:0], rx_gain[33:17], phase[34], gains_changed[35], zero fill
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);
    agc_pkg::agc_cmd_t    cmd;
    agc_pkg::agc_status_t status;
    logic in_fire, out_fire, cfg_fire;
    logic [16:0] tx_gain, rx_gain;
    logic phase, gains_changed;

    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    // configuration is accepted only while no item is in flight
    assign cfg_ready = s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;

    agc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .status(status), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid)
    );

    agc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_fire(in_fire), .in_data(s_tdata[144:0]),
        .cfg_fire(cfg_fire), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .tx_gain(tx_gain), .rx_gain(rx_gain), .phase(phase),
        .gains_changed(gains_changed)
    );

    assign m_tdata = {4'd0, gains_changed, phase, rx_gain, tx_gain};
endmodule

### design/agc_ctrl.sv
// agc_ctrl: sequencer for one update item
// depends on agc_pkg
`timescale 1ns / 1ps
module agc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_fire,
    input  agc_pkg::agc_status_t status,
    output agc_pkg::agc_cmd_t    cmd,
    output logic                 in_ready,
    output logic                 out_valid
);
    agc_pkg::agc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= agc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            agc_pkg::ST_IDLE:   if (in_fire) state_next = agc_pkg::ST_LOAD;
            agc_pkg::ST_LOAD:   state_next = agc_pkg::ST_POWER;
            agc_pkg::ST_POWER:  state_next = agc_pkg::ST_EMA;
            agc_pkg::ST_EMA:    state_next = agc_pkg::ST_DECIDE;
            agc_pkg::ST_DECIDE: state_next = agc_pkg::ST_BRANCH;
            // decide flags are registered, so branch in the cycle after decide
            agc_pkg::ST_BRANCH: begin
                if (status.need_ratio) state_next = agc_pkg::ST_DIV;
                else if (status.need_scale) state_next = agc_pkg::ST_SCALE;
                else state_next = agc_pkg::ST_DONE;
            end
            agc_pkg::ST_DIV:    if (!status.div_busy) state_next = agc_pkg::ST_FACTOR;
            agc_pkg::ST_FACTOR: state_next = agc_pkg::ST_SMOOTH;
            agc_pkg::ST_SMOOTH: state_next = agc_pkg::ST_SCALE;
            agc_pkg::ST_SCALE:  state_next = agc_pkg::ST_DONE;
            agc_pkg::ST_DONE:   if (out_fire) state_next = agc_pkg::ST_IDLE;
            default:            state_next = agc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            agc_pkg::ST_IDLE:   in_ready = 1'b1;
            agc_pkg::ST_LOAD:   cmd.load = 1'b1;
            agc_pkg::ST_POWER:  cmd.power = 1'b1;
            agc_pkg::ST_EMA:    cmd.ema = 1'b1;
            agc_pkg::ST_DECIDE: cmd.decide = 1'b1;
            agc_pkg::ST_BRANCH: cmd.div_start = status.need_ratio;
            agc_pkg::ST_DIV:    ;
            agc_pkg::ST_FACTOR: cmd.factor = 1'b1;
            agc_pkg::ST_SMOOTH: cmd.smooth = 1'b1;
            agc_pkg::ST_SCALE:  cmd.scale = 1'b1;
            agc_pkg::ST_DONE:   out_valid = 1'b1;
            default:            ;
        endcase
    end
endmodule

### design/agc_div.sv
// agc_div: radix-2 restoring divider, 40-bit dividend by 32-bit divisor
// depends on nothing beyond the clock and reset
`timescale 1ns / 1ps
module agc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [39:0] quotient
);
    logic [5:0]  count_reg, count_next;
    logic [39:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    always_comb begin
        count_next = count_reg;
        quot_next = quot_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        shifted = {rem_reg[31:0], quot_reg[39]};
        trial = shifted - {1'b0, dsr_reg};
        if (start) begin
            count_next = 6'd40;
            quot_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (count_reg != 6'd0) begin
            count_next = count_reg - 6'd1;
            if (!trial[32]) begin
                rem_next = trial;
                quot_next = {quot_reg[38:0], 1'b1};
            end else begin
                rem_next = shifted;
                quot_next = {quot_reg[38:0], 1'b0};
            end
        end
    end

    assign busy = (count_reg != 6'd0);
    assign quotient = quot_reg;
endmodule

### design/agc_dp.sv
// agc_dp: gain control datapath with state, guards, search and loop math
// depends on agc_pkg and agc_div
`timescale 1ns / 1ps
module agc_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  agc_pkg::agc_cmd_t    cmd,
    output agc_pkg::agc_status_t status,
    input  logic                 in_fire,
    input  logic [144:0]         in_data,
    input  logic                 cfg_fire,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    output logic [16:0]          tx_gain,
    output logic [16:0]          rx_gain,
    output logic                 phase,
    output logic                 gains_changed
);
    // configuration
    logic        enable_reg;
    logic [15:0] rms_min_reg, rms_max_reg, alpha_reg, attack_reg, release_reg;
    logic [23:0] target_reg;
    logic [3:0]  echo_limit_reg;

    // held item
    logic [31:0] now_reg, sync_in_reg, pkt_in_reg, cor_in_reg;
    logic [15:0] rms_reg;
    logic        freeze_reg;

    // block state
    logic        steady_reg, started_reg, cal_done_reg;
    logic [31:0] start_time_reg, last_adj_reg;
    logic [2:0]  settle_reg;
    logic [31:0] prev_sync_reg, prev_pkt_reg, prev_cor_reg, pavg_reg;
    logic [16:0] smooth_reg, tx_lo_reg, tx_hi_reg, rx_lo_reg, rx_hi_reg;
    logic [4:0]  tx_steps_reg, rx_steps_reg;
    logic [16:0] best_tx_reg, best_rx_reg;
    logic [3:0]  echo_run_reg;
    logic [16:0] tx_reg, rx_reg, old_tx_reg, old_rx_reg;

    // scratch
    logic        active_reg, do_cal_reg, do_steady_reg;
    logic [31:0] p_reg;
    logic [31:0] ds_reg, dp_reg, dc_reg;
    logic        need_ratio_reg, need_scale_reg, scale_tx_reg;
    logic [16:0] scale_k_reg, scale_g_reg;
    logic        sil_pending_reg;
    logic [15:0] weight_reg;
    logic [47:0] factor_reg;

    // divider
    logic        div_busy;
    logic [39:0] div_q;

    agc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend({target_reg, 16'd0}), .divisor(pavg_reg),
        .busy(div_busy), .quotient(div_q)
    );

    assign status.need_ratio = need_ratio_reg;
    assign status.need_scale = need_scale_reg;
    assign status.div_busy = div_busy;

    function automatic logic [16:0] clamp17(input logic [33:0] v, input logic [16:0] lo,
                                           input logic [16:0] hi);
        if (v < {17'd0, lo}) return lo;
        if (v > {17'd0, hi}) return hi;
        return v[16:0];
    endfunction

    // combinational helpers
    logic [31:0] elapsed, since_adj;
    logic [31:0] ds_w, dp_w, dc_w;
    logic [33:0] scale_prod;
    logic [16:0] scale_res;
    logic [31:0] ema_a;
    logic [49:0] ema_sum;
    logic [35:0] p6, t5, p5, t6;
    logic [63:0] smooth_prod;
    logic [16:0] smooth_new, smooth_diff;
    logic [56:0] fac_w;
    logic [31:0] pw;
    logic        in_rng;
    logic [3:0]  echo_w;
    logic        echo_fire;

    assign elapsed = now_reg - start_time_reg;
    assign since_adj = now_reg - last_adj_reg;
    assign ds_w = sync_in_reg - prev_sync_reg;
    assign dp_w = pkt_in_reg - prev_pkt_reg;
    assign dc_w = cor_in_reg - prev_cor_reg;
    assign scale_prod = scale_g_reg * scale_k_reg + 34'd32768;
    assign in_rng = (rms_reg >= rms_min_reg) && (rms_reg <= rms_max_reg);
    assign pw = 32'(rms_reg) * 32'(rms_reg);
    assign ema_a = {16'd0, alpha_reg};
    assign ema_sum = (50'(17'h10000 - {1'b0, alpha_reg}) * pavg_reg)
                     + (50'(ema_a) * p_reg) + 50'd32768;
    assign p6 = 36'(pavg_reg) * 36'd6;
    assign p5 = 36'(pavg_reg) * 36'd5;
    assign t5 = 36'(target_reg) * 36'd5;
    assign t6 = 36'(target_reg) * 36'd6;
    assign fac_w = {24'd0, 17'h10000 - {1'b0, weight_reg}, 16'd0}
                   + 57'(weight_reg) * 57'(div_q);
    assign smooth_prod = 64'(smooth_reg) * 64'(factor_reg[46:0]) + 64'h80000000;
    assign smooth_new = clamp17({2'b0, smooth_prod[63:32]} > 34'h1ffff ? 34'h1ffff
                                : smooth_prod[49:32], agc_pkg::RX_MIN, agc_pkg::RX_MAX);
    assign smooth_diff = (smooth_new > rx_reg) ? smooth_new - rx_reg : rx_reg - smooth_new;

    always_comb begin
        scale_res = scale_tx_reg
            ? clamp17({16'd0, scale_prod[33:16]}, agc_pkg::TX_MIN, agc_pkg::TX_MAX)
            : clamp17({16'd0, scale_prod[33:16]}, agc_pkg::RX_MIN, agc_pkg::RX_MAX);
    end

    // echo counter update and trigger, from the deltas of this item
    always_comb begin
        echo_w = echo_run_reg;
        if (dp_reg != 32'd0) echo_w = 4'd0;
        else if (ds_reg != 32'd0 && dc_reg >= ds_reg && echo_run_reg != 4'd15)
            echo_w = echo_run_reg + 4'd1;
        echo_fire = (echo_w >= echo_limit_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rms_min_reg <= 16'd1638;
            rms_max_reg <= 16'd22938;
            target_reg <= 24'd167772;
            alpha_reg <= 16'd6554;
            attack_reg <= 16'd9830;
            release_reg <= 16'd1966;
            echo_limit_reg <= 4'd3;
        end else if (cfg_fire) begin
            case (cfg_index)
                agc_pkg::CFG_RMS_MIN: rms_min_reg <= cfg_data[15:0];
                agc_pkg::CFG_RMS_MAX: rms_max_reg <= cfg_data[15:0];
                agc_pkg::CFG_TARGET:  target_reg <= cfg_data;
                agc_pkg::CFG_ALPHA:   alpha_reg <= cfg_data[15:0];
                agc_pkg::CFG_ATTACK:  attack_reg <= cfg_data[15:0];
                agc_pkg::CFG_RELEASE: release_reg <= cfg_data[15:0];
                agc_pkg::CFG_ECHO:    echo_limit_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_fire && cfg_index == agc_pkg::CFG_ENABLE) begin
            enable_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            now_reg <= in_data[31:0];
            rms_reg <= in_data[47:32];
            sync_in_reg <= in_data[79:48];
            pkt_in_reg <= in_data[111:80];
            cor_in_reg <= in_data[143:112];
            freeze_reg <= in_data[144];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steady_reg <= 1'b0;
            started_reg <= 1'b0;
            cal_done_reg <= 1'b0;
            start_time_reg <= '0;
            last_adj_reg <= '0;
            settle_reg <= 3'd1;
            prev_sync_reg <= '0;
            prev_pkt_reg <= '0;
            prev_cor_reg <= '0;
            pavg_reg <= '0;
            smooth_reg <= agc_pkg::UNITY;
            tx_lo_reg <= agc_pkg::TX_MIN;
            tx_hi_reg <= agc_pkg::TX_MAX;
            rx_lo_reg <= agc_pkg::RX_MIN;
            rx_hi_reg <= agc_pkg::RX_MAX;
            tx_steps_reg <= '0;
            rx_steps_reg <= '0;
            best_tx_reg <= agc_pkg::UNITY;
            best_rx_reg <= agc_pkg::UNITY;
            echo_run_reg <= '0;
            tx_reg <= agc_pkg::UNITY;
            rx_reg <= agc_pkg::UNITY;
            old_tx_reg <= agc_pkg::UNITY;
            old_rx_reg <= agc_pkg::UNITY;
            active_reg <= 1'b0;
            do_cal_reg <= 1'b0;
            do_steady_reg <= 1'b0;
            need_ratio_reg <= 1'b0;
            need_scale_reg <= 1'b0;
            sil_pending_reg <= 1'b0;
            scale_tx_reg <= 1'b0;
        end else begin
            // start of item: old gains, active flag, cleared flags and start time
            if (cmd.load) begin
                old_tx_reg <= tx_reg;
                old_rx_reg <= rx_reg;
                active_reg <= enable_reg && !freeze_reg;
                need_ratio_reg <= 1'b0;
                need_scale_reg <= 1'b0;
                sil_pending_reg <= 1'b0;
                do_cal_reg <= 1'b0;
                do_steady_reg <= 1'b0;
                if (enable_reg && !freeze_reg && !started_reg) begin
                    started_reg <= 1'b1;
                    start_time_reg <= now_reg;
                end
            end
            // mode and gate decisions, power sample
            if (cmd.power && active_reg) begin
                p_reg <= 32'((33'(pw) + 33'd32) >> 6);
                if (!steady_reg && (elapsed >= agc_pkg::CAL_TIMEOUT || cal_done_reg)) begin
                    steady_reg <= 1'b1;
                    settle_reg <= agc_pkg::STEADY_SETTLE;
                    smooth_reg <= rx_reg;
                    do_steady_reg <= (since_adj >= 32'(agc_pkg::STEADY_SETTLE));
                end else if (!steady_reg) begin
                    do_cal_reg <= (since_adj >= ((elapsed < agc_pkg::CAL_SLOW_AFTER)
                                                 ? 32'd1 : 32'd2));
                end else begin
                    do_steady_reg <= (since_adj >= 32'(settle_reg));
                end
            end
            // power average and deltas
            if (cmd.ema && (do_cal_reg || do_steady_reg)) begin
                if (pavg_reg == 32'd0) pavg_reg <= p_reg;
                else pavg_reg <= ema_sum[47:16];
                ds_reg <= ds_w;
                dp_reg <= dp_w;
                dc_reg <= dc_w;
                prev_sync_reg <= sync_in_reg;
                prev_pkt_reg <= pkt_in_reg;
                prev_cor_reg <= cor_in_reg;
            end
            // guards, search and loop entry
            if (cmd.decide && (do_cal_reg || do_steady_reg)) begin
                last_adj_reg <= now_reg;
                if (do_cal_reg) begin
                    if (rms_reg > rms_max_reg && rx_reg > agc_pkg::RX_MIN) begin
                        need_scale_reg <= 1'b1;
                        scale_tx_reg <= 1'b0;
                        scale_g_reg <= rx_reg;
                        scale_k_reg <= agc_pkg::DOWN_3DB;
                    end else begin
                        echo_run_reg <= echo_fire ? 4'd0 : echo_w;
                        if (echo_fire && tx_reg > agc_pkg::TX_MIN) begin
                            need_scale_reg <= 1'b1;
                            scale_tx_reg <= 1'b1;
                            scale_g_reg <= tx_reg;
                            scale_k_reg <= agc_pkg::DOWN_3DB;
                        end else if (dp_reg != 32'd0 && in_rng) begin
                            best_tx_reg <= tx_reg;
                            best_rx_reg <= rx_reg;
                            cal_done_reg <= 1'b1;
                        end else if (tx_steps_reg < 5'(agc_pkg::SEARCH_STEPS)) begin
                            tx_hi_reg <= clamp17(34'(({1'b0, tx_lo_reg} + {1'b0, tx_hi_reg})
                                         >> 1), agc_pkg::TX_MIN, agc_pkg::TX_MAX);
                            tx_reg <= clamp17(34'(({1'b0, tx_lo_reg} + {1'b0, tx_hi_reg})
                                         >> 1), agc_pkg::TX_MIN, agc_pkg::TX_MAX);
                            tx_steps_reg <= tx_steps_reg + 5'd1;
                        end else if (rx_steps_reg < 5'(agc_pkg::SEARCH_STEPS)) begin
                            rx_hi_reg <= clamp17(34'(({1'b0, rx_lo_reg} + {1'b0, rx_hi_reg})
                                         >> 1), agc_pkg::RX_MIN, agc_pkg::RX_MAX);
                            rx_reg <= clamp17(34'(({1'b0, rx_lo_reg} + {1'b0, rx_hi_reg})
                                         >> 1), agc_pkg::RX_MIN, agc_pkg::RX_MAX);
                            rx_steps_reg <= rx_steps_reg + 5'd1;
                        end else begin
                            tx_reg <= best_tx_reg;
                            rx_reg <= best_rx_reg;
                            cal_done_reg <= 1'b1;
                        end
                    end
                end else begin
                    // steady: echo first, then clip, then loop and silence
                    echo_run_reg <= echo_fire ? 4'd0 : echo_w;
                    if (echo_fire && tx_reg > agc_pkg::TX_MIN) begin
                        need_scale_reg <= 1'b1;
                        scale_tx_reg <= 1'b1;
                        scale_g_reg <= tx_reg;
                        scale_k_reg <= agc_pkg::DOWN_3DB;
                    end else if (rms_reg > rms_max_reg && rx_reg > agc_pkg::RX_MIN) begin
                        need_scale_reg <= 1'b1;
                        scale_tx_reg <= 1'b0;
                        scale_g_reg <= rx_reg;
                        scale_k_reg <= agc_pkg::DOWN_3DB;
                    end else begin
                        sil_pending_reg <= (ds_reg == 32'd0 && dp_reg == 32'd0
                                            && rms_reg < rms_min_reg);
                        if (pavg_reg != 32'd0 && !(p6 >= t5 && p5 <= t6)) begin
                            need_ratio_reg <= 1'b1;
                            weight_reg <= (p5 > t6) ? attack_reg : release_reg;
                        end else if (ds_reg == 32'd0 && dp_reg == 32'd0
                                     && rms_reg < rms_min_reg) begin
                            need_scale_reg <= 1'b1;
                            if (rx_reg < agc_pkg::RX_MAX) begin
                                scale_tx_reg <= 1'b0;
                                scale_g_reg <= rx_reg;
                                scale_k_reg <= agc_pkg::UP_3DB;
                            end else begin
                                scale_tx_reg <= 1'b1;
                                scale_g_reg <= tx_reg;
                                scale_k_reg <= (tx_reg < agc_pkg::TX_MAX)
                                               ? agc_pkg::UP_1P5DB : 17'h10000;
                            end
                        end
                    end
                end
            end
            if (cmd.factor) begin
                factor_reg <= (fac_w > 57'h400000000000) ? 48'h400000000000 : fac_w[47:0];
            end
            if (cmd.smooth) begin
                smooth_reg <= smooth_new;
                if (smooth_diff > agc_pkg::SMOOTH_TOL) rx_reg <= smooth_new;
                if (sil_pending_reg) begin
                    need_scale_reg <= 1'b1;
                    if ((smooth_diff > agc_pkg::SMOOTH_TOL ? smooth_new : rx_reg)
                        < agc_pkg::RX_MAX) begin
                        scale_tx_reg <= 1'b0;
                        scale_g_reg <= (smooth_diff > agc_pkg::SMOOTH_TOL)
                                       ? smooth_new : rx_reg;
                        scale_k_reg <= agc_pkg::UP_3DB;
                    end else begin
                        scale_tx_reg <= 1'b1;
                        scale_g_reg <= tx_reg;
                        scale_k_reg <= (tx_reg < agc_pkg::TX_MAX)
                                       ? agc_pkg::UP_1P5DB : 17'h10000;
                    end
                end
            end
            if (cmd.scale && need_scale_reg) begin
                if (scale_tx_reg) tx_reg <= scale_res;
                else rx_reg <= scale_res;
            end
        end
    end

    assign tx_gain = tx_reg;
    assign rx_gain = rx_reg;
    assign phase = steady_reg;
    assign gains_changed = (tx_reg != old_tx_reg) || (rx_reg != old_rx_reg);
endmodule

### design/agc_checker.sv
// agc_checker: port-level checks on the gain controller
// depends on audio_gain_controller ports
`timescale 1ns / 1ps
module agc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata
);
    // one item in flight: no input taken while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    // steady phase never goes back to calibration
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |=> m_tdata[34]) else $error("phase fell");
    // accepted item is followed by load, not by a result
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind audio_gain_controller agc_checker u_agc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### bench/tb_audio_gain_controller.sv
// tb_audio_gain_controller: self-checking bench for the audio gain controller
// a scoreboard class predicts every result from accepted updates and register writes
// depends on agc_pkg and the audio_gain_controller rtl
`timescale 1ns / 1ps
module tb_audio_gain_controller;
    import agc_pkg::*;

    // gain predictor plus the queue of results still owed by the block
    class agc_scoreboard;
        // register mirror
        bit        en;
        bit [15:0] rms_lo, rms_hi, alpha, w_attack, w_release;
        bit [23:0] target;
        bit [3:0]  echo_lim;
        // controller state
        bit          steady, started, cal_done;
        int unsigned t_start, t_adjust, settle;
        int unsigned last_sync, last_pkt, last_bad, avg_power;
        int unsigned smooth, tx, rx;
        int unsigned bound[4], steps[2], best[2];
        bit [3:0]    echo_cnt;
        logic [39:0] owed[$];
        int          errors;

        function new();
            en = 1; rms_lo = 1638; rms_hi = 22938; target = 167772;
            alpha = 6554; w_attack = 9830; w_release = 1966; echo_lim = 3;
            steady = 0; started = 0; cal_done = 0;
            t_start = 0; t_adjust = 0; settle = 1;
            last_sync = 0; last_pkt = 0; last_bad = 0; avg_power = 0;
            smooth = UNITY; tx = UNITY; rx = UNITY;
            bound[0] = TX_MIN; bound[1] = TX_MAX; bound[2] = RX_MIN; bound[3] = RX_MAX;
            steps[0] = 0; steps[1] = 0; best[0] = UNITY; best[1] = UNITY;
            echo_cnt = 0; errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [23:0] val);
            case (idx)
                CFG_ENABLE:  en = val[0];
                CFG_RMS_MIN: rms_lo = val[15:0];
                CFG_RMS_MAX: rms_hi = val[15:0];
                CFG_TARGET:  target = val;
                CFG_ALPHA:   alpha = val[15:0];
                CFG_ATTACK:  w_attack = val[15:0];
                CFG_RELEASE: w_release = val[15:0];
                CFG_ECHO:    echo_lim = val[3:0];
                default: ;
            endcase
        endfunction

        function int unsigned clampv(longint unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return int'(v);
        endfunction

        function int unsigned db_step(int unsigned g, int unsigned k,
                                      int unsigned lo, int unsigned hi);
            longint unsigned prod;
            prod = longint'(g) * k + 32768;
            return clampv(prod >> 16, lo, hi);
        endfunction

        function void track_power(int unsigned level);
            longint unsigned p, a;
            p = (longint'(level) * level + 32) >> 6;
            a = alpha;
            if (avg_power == 0) avg_power = p[31:0];
            else avg_power = 32'(((65536 - a) * avg_power + a * p + 32768) >> 16);
        endfunction

        function bit clip_cut(int unsigned level, int unsigned now);
            if (level > rms_hi && rx > RX_MIN) begin
                rx = db_step(rx, DOWN_3DB, RX_MIN, RX_MAX);
                t_adjust = now;
                return 1;
            end
            return 0;
        endfunction

        // corrupt-only windows count up until the tx gain gets cut
        function bit echo_cut(int unsigned ds, int unsigned dp, int unsigned dc,
                              int unsigned now);
            if (dp != 0) echo_cnt = 0;
            else if (ds != 0 && dc >= ds && echo_cnt < 15) echo_cnt++;
            if (echo_cnt >= echo_lim) begin
                echo_cnt = 0;
                if (tx > TX_MIN) begin
                    tx = db_step(tx, DOWN_3DB, TX_MIN, TX_MAX);
                    t_adjust = now;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void ratio_track();
            longint unsigned p, t, b, ratio, factor, prod;
            int unsigned diff;
            p = avg_power;
            t = target;
            if (p == 0) return;
            if (6 * p >= 5 * t && 5 * p <= 6 * t) return;
            b = (5 * p > 6 * t) ? w_attack : w_release;
            ratio = (t << 16) / p;
            factor = ((65536 - b) << 16) + b * ratio;
            if (factor > (64'd1 << 46)) factor = 64'd1 << 46;
            prod = longint'(smooth & 32'h1FFFF) * factor + 64'h8000_0000;
            smooth = clampv(prod >> 32, RX_MIN, RX_MAX);
            diff = (smooth > rx) ? smooth - rx : rx - smooth;
            if (diff > SMOOTH_TOL) rx = smooth;
        endfunction

        function void deltas(logic [151:0] d, output int unsigned ds, dp, dc);
            ds = d[79:48] - last_sync;
            dp = d[111:80] - last_pkt;
            dc = d[143:112] - last_bad;
            last_sync = d[79:48];
            last_pkt = d[111:80];
            last_bad = d[143:112];
        endfunction

        function void search(logic [151:0] d, int unsigned level, int unsigned now);
            int unsigned ds, dp, dc, mid;
            track_power(level);
            deltas(d, ds, dp, dc);
            if (clip_cut(level, now)) return;
            if (echo_cut(ds, dp, dc, now)) return;
            if (dp != 0 && level >= rms_lo && level <= rms_hi) begin
                best[0] = tx; best[1] = rx; cal_done = 1;
                return;
            end
            if (steps[0] < SEARCH_STEPS) begin
                mid = clampv((longint'(bound[0]) + bound[1]) >> 1, TX_MIN, TX_MAX);
                bound[1] = mid; steps[0]++; tx = mid;
                return;
            end
            if (steps[1] < SEARCH_STEPS) begin
                mid = clampv((longint'(bound[2]) + bound[3]) >> 1, RX_MIN, RX_MAX);
                bound[3] = mid; steps[1]++; rx = mid;
                return;
            end
            tx = best[0]; rx = best[1]; cal_done = 1;
        endfunction

        function void track(logic [151:0] d, int unsigned level, int unsigned now);
            int unsigned ds, dp, dc;
            if (now - t_adjust < settle) return;
            deltas(d, ds, dp, dc);
            track_power(level);
            if (!echo_cut(ds, dp, dc, now) && !clip_cut(level, now)) begin
                ratio_track();
                if (ds == 0 && dp == 0 && level < rms_lo) begin
                    // silence: raise rx first, then tx once rx is at its ceiling
                    if (rx < RX_MAX) begin
                        rx = db_step(rx, UP_3DB, RX_MIN, RX_MAX);
                        t_adjust = now;
                    end else if (tx < TX_MAX) begin
                        tx = db_step(tx, UP_1P5DB, TX_MIN, TX_MAX);
                        t_adjust = now;
                    end
                end
            end
            t_adjust = now;
        endfunction

        // accepted update: advance the predictor and queue the result it owes
        function void note_update(logic [151:0] d);
            int unsigned now, level, old_tx, old_rx, elapsed;
            logic [39:0] r;
            now = d[31:0]; level = d[47:32];
            old_tx = tx; old_rx = rx;
            if (en && !d[144]) begin
                if (!started) begin
                    started = 1; t_start = now;
                end
                elapsed = now - t_start;
                if (!steady && (elapsed >= CAL_TIMEOUT || cal_done)) begin
                    steady = 1; settle = STEADY_SETTLE; smooth = rx;
                end
                if (!steady) begin
                    if (now - t_adjust >= ((elapsed < CAL_SLOW_AFTER) ? 1 : 2)) begin
                        search(d, level, now);
                        t_adjust = now;
                    end
                end else begin
                    track(d, level, now);
                end
            end
            r = '0;
            r[16:0] = tx[16:0];
            r[33:17] = rx[16:0];
            r[34] = steady;
            r[35] = (tx != old_tx || rx != old_rx);
            owed.push_back(r);
        endfunction

        function void check_result(logic [39:0] got);
            logic [39:0] e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction %h", got);
                return;
            end
            e = owed.pop_front();
            if (got[16:0] !== e[16:0] || got[33:17] !== e[33:17] ||
                got[34] !== e[34] || got[35] !== e[35]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: tx %0d/%0d rx %0d/%0d phase %0b/%0b chg %0b/%0b (exp/got)",
                             e[16:0], got[16:0], e[33:17], got[33:17],
                             e[34], got[34], e[35], got[35]);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [39:0]  m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = CFG_ENABLE;
    logic [23:0]  cfg_data = '0;

    agc_scoreboard gain_sb = new();

    // stimulus side view of the link: running time and counters
    int unsigned t_now = 100, n_sync = 32'hFFFF_FFF0, n_pkt = 32'hFFFF_FFF8, n_bad = 0;
    bit          calm = 0;        // no idling on either side while set
    bit          hold_req = 0;    // asks the receiver for a long hold-off
    int          quiet_cycles = 0;

    audio_gain_controller DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // every accepted transaction goes to the scoreboard at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) gain_sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) gain_sb.note_update(s_tdata);
            if (m_tvalid && m_tready) gain_sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 29);
            end
        end
    end

    function bit idle_roll();
        return !calm && $urandom_range(0, 99) < 29;
    endfunction

    // offer one update and hold it until the block takes the transaction
    task automatic send_update(logic [151:0] d);
        @(negedge aclk);
        while (idle_roll()) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge aclk);
        s_tvalid <= 0;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // let every owed result come back, then give the block time to go idle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 0;
        while (gain_sb.owed.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_regs(bit en, int unsigned lo, int unsigned hi, int unsigned tgt,
                            int unsigned a, int unsigned att, int unsigned rel,
                            int unsigned el);
        drain();
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_RMS_MIN, lo);
        write_reg(CFG_RMS_MAX, hi);
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_ECHO, el);
    endtask

    // advance the link by the given steps and send the update
    task automatic link_step(int unsigned dt, int unsigned level, int unsigned ds,
                             int unsigned dp, int unsigned dc, bit frz);
        t_now += dt; n_sync += ds; n_pkt += dp; n_bad += dc;
        send_update({7'd0, frz, n_bad, n_pkt, n_sync, level[15:0], t_now});
    endtask

    task automatic random_updates(int count);
        int unsigned level, ds, kind;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                // noise: every field at random, the link view jumps with it
                t_now = $urandom; n_sync = $urandom; n_pkt = $urandom; n_bad = $urandom;
                link_step(0, $urandom_range(0, 65535), 0, 0, 0, $urandom_range(0, 1));
            end else begin
                case ($urandom_range(0, 3))
                    0: level = $urandom_range(0, 1600);
                    1: level = $urandom_range(1700, 22000);
                    2: level = $urandom_range(23000, 65535);
                    default: level = $urandom_range(0, 65535);
                endcase
                ds = $urandom_range(0, 3);
                if ($urandom_range(0, 99) < 45)
                    link_step($urandom_range(0, 7), level, ds, 0, $urandom_range(0, 4),
                              $urandom_range(0, 99) < 5);
                else
                    link_step($urandom_range(0, 7), level, ds, $urandom_range(1, 3),
                              $urandom_range(0, 1), $urandom_range(0, 99) < 5);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: calibration search, guards, freeze, wrap and a backward clock
        link_step(0, 3000, 0, 0, 0, 1);          // frozen before start
        for (int i = 0; i < 4; i++) link_step(1, 3000, 0, 0, 0, 0);   // tx search steps
        link_step(1, 65535, 0, 0, 0, 0);         // clip
        link_step(1, 0, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++) link_step(2, 3000, 2, 0, 3, 0);   // corrupt-only
        link_step(2, 30000, 1, 0, 0, 0);
        link_step(2, 3000, 1, 1, 0, 0);          // good window ends calibration
        link_step(1, 3000, 0, 0, 0, 0);          // enters steady
        link_step(5, 65535, 0, 0, 0, 0);
        link_step(5, 0, 0, 0, 0, 0);             // silence
        link_step(5, 0, 0, 0, 0, 0);
        link_step(5, 20000, 3, 0, 5, 0);
        link_step(5, 20000, 3, 0, 5, 1);
        link_step(5, 1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        link_step(32'hFFFF_FFF0, 3000, 1, 1, 1, 0);   // clock goes backward
        link_step(32'hFFFF_FFFF, 65535, 0, 0, 0, 0);

        random_updates(230);
        hold_req = 1;                            // receiver stalls, block fills up
        random_updates(20);

        set_regs(1, 0, 65535, 1, 0, 0, 0, 1);
        random_updates(150);
        set_regs(1, 65535, 0, 24'hFFFFFF, 65535, 65535, 65535, 15);
        random_updates(150);
        set_regs(0, 1638, 22938, 167772, 6554, 9830, 1966, 3);
        random_updates(60);
        set_regs(1, 1638, 22938, 167772, 65535, 65535, 1966, 2);
        calm = 1;
        random_updates(150);
        calm = 0;
        set_regs(1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(1, 24'hFFFFFF), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(1, 15));
        random_updates(170);
        set_regs(1, 1638, 22938, 167772, 6554, 9830, 1966, 3);
        random_updates(200);

        drain();
        if (gain_sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### sim.f
design/agc_pkg.sv
design/agc_ctrl.sv
design/agc_div.sv
design/agc_dp.sv
design/audio_gain_controller.sv
design/agc_checker.sv
bench/tb_audio_gain_controller.sv
